// ===== design/rgb_histogram_normalizer_top_assert.svh =====
// Assertion macros for the RGB histogram normaliser top level.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef RGB_HISTOGRAM_NORMALIZER_TOP_ASSERT_SVH
`define RGB_HISTOGRAM_NORMALIZER_TOP_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted
`define RHN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define RHN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rhn_pkg.sv =====
// Shared types and fixed constants of the RGB histogram normaliser.
// No dependencies.
`default_nettype none

package rhn_pkg;

    // Fixed field widths of the command beat
    localparam int OP_W      = 2;
    localparam int VAL_W     = 8;
    localparam int VAL_COUNT = 2 ** VAL_W;
    localparam int NUM_CH    = 3;

    // Command codes
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_PIXEL  = 2'd1,
        OP_FINISH = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_LOAD  = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_DIV   = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

// ===== design/rgb_histogram_normalizer_top.sv =====
// RGB histogram normaliser: three banked bin memories with a read-modify-write
// pixel path, a min/max scanner and a shared-step restoring divider per channel.
// Depends on rhn_pkg and rgb_histogram_normalizer_top_assert.svh.
//
// A command beat is taken when start is high and busy is low. Add pixel leaves busy
// low and may follow itself every cycle: each colour has its own bin memory with
// separate read and write ports, read and then written back in the next cycle,
// with the last write forwarded when the same bin is hit twice in a row. Clear keeps
// busy high while one bin per cycle is zeroed; the same sweep runs after reset, so
// the block is busy after reset is released. Finish keeps busy high while one bin is
// read per cycle, then through a drain state that folds the last count. Read bin
// keeps busy high while it loads and clamps, then scales, then divides with one
// quotient bit retired per cycle into HW bits, HW = clog2(HEIGHT + 1). Its result
// appears on the o_ ports in the cycle that busy falls, marked by o_strobe, which
// is high for a single cycle, and the receiver cannot hold it off.
`default_nettype none

`include "rgb_histogram_normalizer_top_assert.svh"

module rgb_histogram_normalizer_top #(
    parameter int BIN_COUNT  = 256,
    parameter int COUNT_BITS = 24,
    parameter int HEIGHT     = 100,
    localparam int HW        = $clog2(HEIGHT + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [rhn_pkg::OP_W-1:0] i_operation,
    input  wire logic [rhn_pkg::VAL_W-1:0] i_red,
    input  wire logic [rhn_pkg::VAL_W-1:0] i_green,
    input  wire logic [rhn_pkg::VAL_W-1:0] i_blue,
    input  wire logic [rhn_pkg::VAL_W-1:0] i_bin,
    output logic                          o_strobe,
    output logic [HW-1:0]                 o_red_height,
    output logic [HW-1:0]                 o_green_height,
    output logic [HW-1:0]                 o_blue_height,
    output logic [COUNT_BITS-1:0]         o_red_count,
    output logic [COUNT_BITS-1:0]         o_green_count,
    output logic [COUNT_BITS-1:0]         o_blue_count
);

    import rhn_pkg::*;

    localparam int CW     = COUNT_BITS;
    localparam int IDX_W  = $clog2(BIN_COUNT);
    localparam int NW     = CW + HW;
    localparam int STEP_W = $clog2(HW) + 1;
    localparam logic [CW-1:0]     COUNT_MAX = '1;
    localparam logic [IDX_W-1:0]  LAST_BIN  = IDX_W'(BIN_COUNT - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(HW - 1);

    // Control registers
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_cnt, n_cnt;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_pix_v, n_pix_v;
    logic               r_wr_v;
    logic               r_scan_v;
    logic               r_strobe, n_strobe;

    t_op                w_op;
    logic               w_accept;
    logic               w_finish_go;
    logic               w_sweep;
    logic [VAL_W-1:0]   w_val [NUM_CH];
    logic [IDX_W-1:0]   w_mod [VAL_COUNT];
    logic [HW-1:0]      w_height [NUM_CH];
    logic [CW-1:0]      w_count [NUM_CH];

    assign w_op        = t_op'(i_operation);
    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && (r_state == S_IDLE);
    assign w_finish_go = w_accept && (w_op == OP_FINISH);
    assign w_sweep     = (r_state == S_CLEAR);

    assign w_val[0] = i_red;
    assign w_val[1] = i_green;
    assign w_val[2] = i_blue;

    // Fold channel values and bin index onto the bin range
    for (genvar v = 0; v < VAL_COUNT; v++) begin : g_mod
        assign w_mod[v] = IDX_W'(v % BIN_COUNT);
    end

    // Sequence pixel accept, clear sweep, scan, and read/divide
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_step   = r_step;
        n_pix_v  = 1'b0;
        n_strobe = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (w_op)
                        OP_CLEAR: begin
                            n_state = S_CLEAR;
                            n_cnt   = '0;
                        end
                        OP_PIXEL:  n_pix_v = 1'b1;
                        OP_FINISH: begin
                            n_state = S_SCAN;
                            n_cnt   = '0;
                        end
                        OP_READ:   n_state = S_LOAD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                n_cnt = IDX_W'(r_cnt + 1'b1);
                if (r_cnt == LAST_BIN) n_state = S_IDLE;
            end
            S_SCAN: begin
                n_cnt = IDX_W'(r_cnt + 1'b1);
                if (r_cnt == LAST_BIN) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_IDLE;
            S_LOAD:  n_state = S_MUL;
            S_MUL: begin
                n_state = S_DIV;
                n_step  = '0;
            end
            S_DIV: begin
                n_step = STEP_W'(r_step + 1'b1);
                if (r_step == LAST_STEP) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold control state; reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_step   <= '0;
            r_pix_v  <= 1'b0;
            r_wr_v   <= 1'b0;
            r_scan_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_step   <= n_step;
            r_pix_v  <= n_pix_v;
            r_wr_v   <= r_pix_v;
            r_scan_v <= (r_state == S_SCAN);
            r_strobe <= n_strobe;
        end
    end

    // One lane per colour: bin memory, min/max, divider
    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        logic [CW-1:0]    r_bins [BIN_COUNT];
        logic [VAL_W-1:0] w_sel;
        logic [IDX_W-1:0] w_rd_addr;
        logic [IDX_W-1:0] r_req_addr;
        logic [IDX_W-1:0] r_wr_addr;
        logic [IDX_W-1:0] w_wr_addr;
        logic             w_wr_en;
        logic [CW-1:0]    r_rd;
        logic [CW-1:0]    r_wr_data;
        logic [CW-1:0]    w_cur;
        logic [CW-1:0]    w_inc;
        logic [CW-1:0]    w_wr_data;
        logic [CW-1:0]    r_min;
        logic [CW-1:0]    r_max;
        logic [CW-1:0]    r_count;
        logic [CW-1:0]    r_diff;
        logic [CW-1:0]    r_den;
        logic             r_flat;
        logic [NW-1:0]    r_num;
        logic [NW-1:0]    r_dsh;
        logic [HW-1:0]    r_q;
        logic             w_ge;

        // Pick the read address: scan counter, pixel value or bin index
        assign w_sel     = (w_op == OP_PIXEL) ? w_val[ch] : i_bin;
        assign w_rd_addr = (r_state == S_SCAN) ? r_cnt : w_mod[w_sel];

        // Forward the write that landed on the edge this read was issued
        assign w_cur = (r_wr_v && (r_wr_addr == r_req_addr)) ? r_wr_data : r_rd;
        assign w_inc = (w_cur == COUNT_MAX) ? w_cur : CW'(w_cur + 1'b1);

        // Write port: clearing sweep or pixel write-back
        assign w_wr_en   = w_sweep || r_pix_v;
        assign w_wr_addr = w_sweep ? r_cnt : r_req_addr;
        assign w_wr_data = w_sweep ? '0 : w_inc;

        always_ff @(posedge i_clk) begin
            if (w_wr_en) begin
                r_bins[w_wr_addr] <= w_wr_data;
            end
            r_rd <= r_bins[w_rd_addr];
        end

        // Track the read address and the last write-back
        always_ff @(posedge i_clk) begin
            r_req_addr <= w_rd_addr;
            r_wr_addr  <= r_req_addr;
            r_wr_data  <= w_inc;
        end

        // Fold each scanned count into the channel minimum and maximum
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_min <= '0;
                r_max <= '0;
            end else if (w_finish_go) begin
                r_min <= COUNT_MAX;
                r_max <= '0;
            end else if (r_scan_v) begin
                if (w_cur < r_min) r_min <= w_cur;
                if (w_cur > r_max) r_max <= w_cur;
            end
        end

        // Clamp against the scanned range, scale, then divide a bit per cycle
        assign w_ge = !r_flat && (r_num >= r_dsh);

        always_ff @(posedge i_clk) begin
            case (r_state)
                S_LOAD: begin
                    r_count <= w_cur;
                    r_flat  <= (r_max <= r_min);
                    r_den   <= CW'(r_max - r_min);
                    if (w_cur <= r_min) begin
                        r_diff <= '0;
                    end else if (w_cur >= r_max) begin
                        r_diff <= CW'(r_max - r_min);
                    end else begin
                        r_diff <= CW'(w_cur - r_min);
                    end
                end
                S_MUL: begin
                    r_num <= NW'(r_diff) * NW'(HEIGHT);
                    r_dsh <= NW'(r_den) << (HW - 1);
                end
                S_DIV: begin
                    if (w_ge) r_num <= NW'(r_num - r_dsh);
                    r_dsh <= r_dsh >> 1;
                    r_q   <= HW'({r_q, w_ge});
                end
                default: ;
            endcase
        end

        assign w_height[ch] = r_q;
        assign w_count[ch]  = r_count;
    end

    // Drive the result beat
    assign o_strobe       = r_strobe;
    assign o_red_height   = w_height[0];
    assign o_green_height = w_height[1];
    assign o_blue_height  = w_height[2];
    assign o_red_count    = w_count[0];
    assign o_green_count  = w_count[1];
    assign o_blue_count   = w_count[2];

    // Checks
    `RHN_ASSERT_NEXT(a_strobe_single, o_strobe, !o_strobe, "result strobe held past one cycle")
    `RHN_ASSERT_NOW(a_pix_wb_idle, r_pix_v, r_state == S_IDLE, "pixel write-back met sweep")
    `RHN_ASSERT_NOW(a_height_range, o_strobe,
        (o_red_height <= HEIGHT) && (o_green_height <= HEIGHT) && (o_blue_height <= HEIGHT),
        "bar height beyond full scale")
    `RHN_ASSERT_NEXT(a_read_to_mul, r_state == S_LOAD, r_state == S_MUL, "read sequence skipped")

endmodule

`default_nettype wire
